// ----- rtl/core/gntm_pkg.sv -----
// Shared constants, types and the arctangent table for the nearest-target matcher.
package gntm_pkg;

   localparam int MAX_ARMORS   = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int ANG_W        = 36;   // CORDIC datapath width, Q.30 angles
   localparam int CNT_W        = 7;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] GAIN_Q30    = 36'sd652032874;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_DET  = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   localparam logic CSR_MAX_DIST = 1'b0;
   localparam logic CSR_MAX_YAW  = 1'b1;

   typedef struct packed {
      logic start;
      logic vectoring;   // 1: atan2 (drive y to zero), 0: rotate by z
   } cordic_ctl_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 36'sd843314857;
         5'd1:  v = 36'sd497837829;
         5'd2:  v = 36'sd263043837;
         5'd3:  v = 36'sd133525159;
         5'd4:  v = 36'sd67021687;
         5'd5:  v = 36'sd33543516;
         5'd6:  v = 36'sd16775851;
         5'd7:  v = 36'sd8388437;
         5'd8:  v = 36'sd4194283;
         5'd9:  v = 36'sd2097149;
         5'd10: v = 36'sd1048576;
         5'd11: v = 36'sd524288;
         5'd12: v = 36'sd262144;
         5'd13: v = 36'sd131072;
         5'd14: v = 36'sd65536;
         5'd15: v = 36'sd32768;
         5'd16: v = 36'sd16384;
         5'd17: v = 36'sd8192;
         5'd18: v = 36'sd4096;
         5'd19: v = 36'sd2048;
         5'd20: v = 36'sd1024;
         5'd21: v = 36'sd512;
         5'd22: v = 36'sd256;
         5'd23: v = 36'sd128;
         5'd24: v = 36'sd64;
         5'd25: v = 36'sd32;
         5'd26: v = 36'sd16;
         5'd27: v = 36'sd8;
         5'd28: v = 36'sd4;
         5'd29: v = 36'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/gntm_cordic.sv -----
// Shared CORDIC unit: one micro-rotation per cycle, rotation or vectoring mode.
module gntm_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  gntm_pkg::cordic_ctl_type       ctl,
   input  logic signed [gntm_pkg::ANG_W-1:0] x_start,
   input  logic signed [gntm_pkg::ANG_W-1:0] y_start,
   input  logic signed [gntm_pkg::ANG_W-1:0] z_start,
   output logic                           done,
   output logic signed [gntm_pkg::ANG_W-1:0] x_out,
   output logic signed [gntm_pkg::ANG_W-1:0] y_out,
   output logic signed [gntm_pkg::ANG_W-1:0] z_out
);
   logic signed [gntm_pkg::ANG_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [gntm_pkg::ANG_W-1:0] x_sh, y_sh, ang;
   logic [4:0] iter_ff;
   logic       busy_ff, done_ff, vec_ff, rot_pos;

   always_comb begin
      x_sh    = x_ff >>> iter_ff;
      y_sh    = y_ff >>> iter_ff;
      ang     = gntm_pkg::atan_q30(iter_ff);
      rot_pos = vec_ff ? y_ff[gntm_pkg::ANG_W-1] : ~z_ff[gntm_pkg::ANG_W-1];
      if (rot_pos) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - ang;
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 5'd1;
            if (iter_ff == 5'(gntm_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff   <= x_start;
         y_ff   <= y_start;
         z_ff   <= z_start;
         vec_ff <= ctl.vectoring;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

// ----- rtl/core/gntm_isqrt.sv -----
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module gntm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] n_start,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] rem_ff, res_ff, rem_in, res_in, bit_v;
   logic [64:0] trial;
   logic [4:0]  iter_ff;
   logic        busy_ff, done_ff;

   always_comb begin
      // bit = 4^(31-iter)
      bit_v = 64'd1 << {~iter_ff, 1'b0};
      trial = {1'b0, res_ff} + {1'b0, bit_v};
      if ({1'b0, rem_ff} >= trial) begin
         rem_in = rem_ff - trial[63:0];
         res_in = (res_ff >> 1) + bit_v;
      end else begin
         rem_in = rem_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= n_start;
         res_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

// ----- rtl/core/gated_nearest_target_match.sv -----
// Gated nearest-target matcher: a load transaction sets the predicted armor pose
// (one modulo-2pi reduction, a 30-step CORDIC sin/cos and two multiplies); each
// detection transaction is bounded by the 32-step square root run alongside the
// CORDIC atan2, then the 15-step modulo reduction of the yaw difference; a
// detection past the 16th of a frame is accepted and dropped without leaving idle.
// An end transaction queues best_index (all ones in its 7 bits if nothing passed
// both gates) in the output register once that register is free. req_tready is
// high only while the sequencer is idle; a waiting result does not stall input
// except a further end transaction.
module gated_nearest_target_match (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // center_x, center_y, center_z, target_yaw, radius, height_offset,
   // armor_x, armor_y, armor_z, quat_z, quat_w
   input  logic [319:0] req_tdata,
   input  logic [1:0]   req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // best_index, zero pad
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [30:0]  csr_wdata
);
   localparam int W = gntm_pkg::ANG_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MOD_INIT = 4'd1;
   localparam logic [3:0] ST_MOD      = 4'd2;
   localparam logic [3:0] ST_LD_FOLD  = 4'd3;
   localparam logic [3:0] ST_LD_ROT   = 4'd4;
   localparam logic [3:0] ST_LD_MULC  = 4'd5;
   localparam logic [3:0] ST_LD_MULS  = 4'd6;
   localparam logic [3:0] ST_LD_FIN   = 4'd7;
   localparam logic [3:0] ST_DT_SQ    = 4'd8;
   localparam logic [3:0] ST_DT_START = 4'd9;
   localparam logic [3:0] ST_DT_WAIT  = 4'd10;
   localparam logic [3:0] ST_DT_CMP   = 4'd11;
   localparam logic [3:0] ST_EMIT     = 4'd12;

   localparam logic [48:0] TWO_PI_49 = 49'(gntm_pkg::TWO_PI_Q30);
   localparam logic [33:0] PI_34     = 34'(gntm_pkg::PI_Q30);
   localparam logic [33:0] TWO_PI_34 = 34'(gntm_pkg::TWO_PI_Q30);

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647)       return 32'sh7FFFFFFF;
      else if (v < -38'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   function automatic logic huge(input logic signed [32:0] v);
      return (v > 33'sd2147483647) || (v < -33'sd2147483647);
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [30:0] max_dist_ff;
   logic [17:0] max_yaw_ff;
   logic signed [31:0] pred_x_ff, pred_y_ff, pred_z_ff, pred_yaw_ff;
   logic [31:0] best_dist_ff;
   logic [gntm_pkg::CNT_W-1:0] best_slot_ff, count_ff;
   logic        rsp_valid_ff;
   logic [6:0]  rsp_data_ff;

   logic signed [31:0] cx_ff, cy_ff, r_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [15:0] qz_ff, qw_ff;
   logic signed [48:0] d_ff;
   logic [48:0] mod_ff, mod_sub;
   logic [3:0]  k_ff;
   logic        is_load_ff, neg_ff;
   logic [1:0]  sq_ff;
   logic signed [65:0] prod_ff;
   logic [63:0] acc_ff;
   logic        cdone_ff, sdone_ff;
   logic signed [W-1:0] zres_ff;
   logic [31:0] dist_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [W-1:0] c_x, c_y, c_z, cx_start, cy_start, cz_start;
   logic signed [W-1:0] ang1, ang2, cos_v, sin_v;
   logic signed [35:0]  rnd;
   logic        fold_neg, zero_quat, cdone, sdone, sqrt_start, req_fire;
   logic [31:0] root;
   gntm_pkg::cordic_ctl_type cctl;
   logic [33:0] ym, ym2;
   logic        yaw_pass, dist_pass;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign mod_sub    = TWO_PI_49 << k_ff;
   assign zero_quat  = (qz_ff == 16'sd0) && (qw_ff == 16'sd0);

   // sin/cos argument fold into [-pi/2, pi/2]
   always_comb begin
      ang1 = (mod_ff[33:0] > PI_34) ? W'(mod_ff[33:0]) - gntm_pkg::TWO_PI_Q30
                                    : W'(mod_ff[33:0]);
      fold_neg = 1'b0;
      ang2     = ang1;
      if (ang1 > gntm_pkg::HALF_PI_Q30) begin
         ang2 = ang1 - gntm_pkg::PI_Q30;  fold_neg = 1'b1;
      end else if (ang1 < -gntm_pkg::HALF_PI_Q30) begin
         ang2 = ang1 + gntm_pkg::PI_Q30;  fold_neg = 1'b1;
      end
   end

   always_comb begin
      cctl       = '0;
      cx_start   = gntm_pkg::GAIN_Q30;
      cy_start   = '0;
      cz_start   = ang2;
      sqrt_start = 1'b0;
      if (state_ff == ST_LD_FOLD) begin
         cctl.start = 1'b1;
      end else if (state_ff == ST_DT_START) begin
         sqrt_start     = 1'b1;
         cctl.start     = ~zero_quat;
         cctl.vectoring = 1'b1;
         if (qw_ff < 0) begin
            cx_start = -(W'(qw_ff) <<< 16);
            cy_start = -(W'(qz_ff) <<< 16);
            cz_start = (qz_ff >= 0) ? gntm_pkg::PI_Q30 : -gntm_pkg::PI_Q30;
         end else begin
            cx_start = W'(qw_ff) <<< 16;
            cy_start = W'(qz_ff) <<< 16;
            cz_start = '0;
         end
      end
   end

   gntm_cordic u_cordic (
      .clock(clock), .reset(reset), .ctl(cctl),
      .x_start(cx_start), .y_start(cy_start), .z_start(cz_start),
      .done(cdone), .x_out(c_x), .y_out(c_y), .z_out(c_z)
   );

   gntm_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .n_start(acc_ff),
      .done(sdone), .root(root)
   );

   assign cos_v = neg_ff ? -c_x : c_x;
   assign sin_v = neg_ff ? -c_y : c_y;

   // shared multiplier operand select
   always_comb begin
      mul_a = cos_v[32:0];
      mul_b = 33'(r_ff);
      case (state_ff)
         ST_LD_MULS: mul_a = sin_v[32:0];
         ST_DT_SQ: begin
            case (sq_ff)
               2'd0:    mul_a = dx_ff;
               2'd1:    mul_a = dy_ff;
               default: mul_a = dz_ff;
            endcase
            mul_b = mul_a;
         end
         default: ;
      endcase
   end

   // Q.46 product rounded to Q16.16
   assign rnd = 36'((prod_ff + 66'sd536870912) >>> 30);

   always_comb begin
      ym        = mod_ff[33:0];
      ym2       = (ym > PI_34) ? TWO_PI_34 - ym : ym;
      yaw_pass  = ym2 < {2'b00, max_yaw_ff, 14'd0};
      dist_pass = !huge(dx_ff) && !huge(dy_ff) && !huge(dz_ff)
                  && ({1'b0, dist_ff} < {2'b00, max_dist_ff})
                  && (dist_ff < best_dist_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  gntm_pkg::ACT_LOAD: state_in = ST_MOD_INIT;
                  gntm_pkg::ACT_DET:
                     if (count_ff < gntm_pkg::CNT_W'(gntm_pkg::MAX_ARMORS))
                        state_in = ST_DT_SQ;
                  gntm_pkg::ACT_END:  state_in = ST_EMIT;
                  default: ;
               endcase
            end
         end
         ST_MOD_INIT: state_in = ST_MOD;
         ST_MOD:      if (k_ff == 4'd0) state_in = is_load_ff ? ST_LD_FOLD : ST_DT_CMP;
         ST_LD_FOLD:  state_in = ST_LD_ROT;
         ST_LD_ROT:   if (cdone) state_in = ST_LD_MULC;
         ST_LD_MULC:  state_in = ST_LD_MULS;
         ST_LD_MULS:  state_in = ST_LD_FIN;
         ST_LD_FIN:   state_in = ST_IDLE;
         ST_DT_SQ:    if (sq_ff == 2'd3) state_in = ST_DT_START;
         ST_DT_START: state_in = ST_DT_WAIT;
         ST_DT_WAIT:  if (cdone_ff && sdone_ff) state_in = ST_MOD_INIT;
         ST_DT_CMP:   state_in = ST_IDLE;
         ST_EMIT:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_dist_ff  <= 31'd32768;
         max_yaw_ff   <= 18'd65536;
         pred_x_ff    <= '0;
         pred_y_ff    <= '0;
         pred_z_ff    <= '0;
         pred_yaw_ff  <= '0;
         best_dist_ff <= '1;
         best_slot_ff <= '1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cdone_ff     <= 1'b0;
         sdone_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            case (csr_addr)
               gntm_pkg::CSR_MAX_DIST: max_dist_ff <= csr_wdata;
               gntm_pkg::CSR_MAX_YAW:  max_yaw_ff  <= csr_wdata[17:0];
               default: ;
            endcase
         end
         if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:
               if (req_fire && req_tuser == gntm_pkg::ACT_LOAD) begin
                  pred_z_ff    <= sat32(38'(signed'(req_tdata[95:64]))
                                        + 38'(signed'(req_tdata[191:160])));
                  pred_yaw_ff  <= req_tdata[127:96];
                  best_dist_ff <= '1;
                  best_slot_ff <= '1;
                  count_ff     <= '0;
               end
            ST_LD_MULS: pred_x_ff <= sat32(38'(cx_ff) - 38'(rnd));
            ST_LD_FIN:  pred_y_ff <= sat32(38'(cy_ff) - 38'(rnd));
            ST_DT_START: begin
               cdone_ff <= zero_quat;
               sdone_ff <= 1'b0;
            end
            ST_DT_WAIT: begin
               if (cdone) cdone_ff <= 1'b1;
               if (sdone) sdone_ff <= 1'b1;
            end
            ST_DT_CMP: begin
               if (yaw_pass && dist_pass) begin
                  best_dist_ff <= dist_ff;
                  best_slot_ff <= count_ff;
               end
               count_ff <= count_ff + 1'b1;
            end
            ST_EMIT:
               if (!rsp_valid_ff || rsp_tready) begin
                  best_dist_ff <= '1;
                  best_slot_ff <= '1;
                  count_ff     <= '0;
               end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cx_ff      <= req_tdata[31:0];
               cy_ff      <= req_tdata[63:32];
               r_ff       <= req_tdata[159:128];
               d_ff       <= 49'(signed'(req_tdata[127:96])) <<< 14;
               is_load_ff <= (req_tuser == gntm_pkg::ACT_LOAD);
               dx_ff      <= 33'(signed'(req_tdata[223:192])) - 33'(pred_x_ff);
               dy_ff      <= 33'(signed'(req_tdata[255:224])) - 33'(pred_y_ff);
               dz_ff      <= 33'(signed'(req_tdata[287:256])) - 33'(pred_z_ff);
               qz_ff      <= req_tdata[303:288];
               qw_ff      <= req_tdata[319:304];
               sq_ff      <= '0;
               acc_ff     <= '0;
            end
         end
         ST_MOD_INIT: begin
            mod_ff <= d_ff[48] ? 49'(d_ff + 49'(TWO_PI_49 << 14)) : 49'(d_ff);
            k_ff   <= 4'd14;
         end
         ST_MOD: begin
            if (mod_ff >= mod_sub) mod_ff <= mod_ff - mod_sub;
            k_ff <= k_ff - 4'd1;
         end
         ST_LD_FOLD: neg_ff <= fold_neg;
         ST_DT_SQ: begin
            sq_ff <= sq_ff + 2'd1;
            if (sq_ff != 2'd0) acc_ff <= acc_ff + prod_ff[63:0];
         end
         ST_DT_START: zres_ff <= '0;
         ST_DT_WAIT: begin
            if (cdone) zres_ff <= c_z;
            if (sdone) dist_ff <= root;
            d_ff <= (49'(zres_ff) <<< 1) - (49'(pred_yaw_ff) <<< 14);
         end
         ST_EMIT:
            if (!rsp_valid_ff || rsp_tready) rsp_data_ff <= best_slot_ff;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gntm_pkg::CNT_W'(gntm_pkg::MAX_ARMORS))
      else $error("detection count past limit");

   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (best_slot_ff == '1) || (best_slot_ff < count_ff))
      else $error("best slot beyond detections seen");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside emit");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DT_WAIT) |-> !req_tready)
      else $error("ready while detection in flight");
`endif
endmodule
